// ===== src/marker_frame_command_receiver_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the marker frame command receiver
// Concurrent assertion wrappers on clk, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef MARKER_FRAME_COMMAND_RECEIVER_CORE_MACROS_SVH
`define MARKER_FRAME_COMMAND_RECEIVER_CORE_MACROS_SVH

// checked only while out of reset
`define MFCR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MFCR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mfcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mfcr_pkg
// Command table, kinds and shared types of the marker frame command receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mfcr_pkg;

	localparam int MAX_PAYLOAD_DEF = 7;
	localparam int NUM_CMDS        = 11;

	// command codes held in the active-command register
	localparam logic [3:0] CMD_IDLE = 4'd0;
	localparam logic [3:0] CMD_CA   = 4'd1;
	localparam logic [3:0] CMD_F5   = 4'd2;
	localparam logic [3:0] CMD_B5   = 4'd3;
	localparam logic [3:0] CMD_EA   = 4'd4;
	localparam logic [3:0] CMD_60   = 4'd5;
	localparam logic [3:0] CMD_E5   = 4'd6;
	localparam logic [3:0] CMD_E7   = 4'd7;
	localparam logic [3:0] CMD_E8   = 4'd8;
	localparam logic [3:0] CMD_E9   = 4'd9;
	localparam logic [3:0] CMD_D1   = 4'd10;
	localparam logic [3:0] CMD_D3   = 4'd11;

	// payload check kinds
	localparam logic [2:0] KIND_LINK  = 3'd0;
	localparam logic [2:0] KIND_RESET = 3'd1;
	localparam logic [2:0] KIND_SUM   = 3'd2;
	localparam logic [2:0] KIND_CTRL  = 3'd3;
	localparam logic [2:0] KIND_DATE  = 3'd4;
	localparam logic [2:0] KIND_TIME  = 3'd5;

	// decimal digit pairs folded into the date and time values
	localparam int DATE_DIGITS = 4;
	localparam int TIME_DIGITS = 3;

	localparam logic [7:0] LINK_PLAIN = 8'h01;
	localparam logic [7:0] LINK_SEND  = 8'h0F;
	localparam logic [7:0] RESET_PAT  = 8'h5F;

	typedef struct packed {
		logic [7:0] marker;
		logic [2:0] len;
		logic [2:0] kind;
		logic [1:0] nreply;
		logic [7:0] reply2;
		logic [7:0] reply1;
		logic [7:0] reply0;
	} cmd_t;

	// side-band fields, first field in the highest bits
	typedef struct packed {
		logic        reset_request;
		logic        send_request;
		logic [7:0]  control_value;
		logic        control_update;
		logic [21:0] time_value;
		logic        time_update;
		logic [27:0] date_value;
		logic        date_update;
	} flags_t;

	// completed good frame, handed from the frame engine to the reply buffer
	typedef struct packed {
		logic       fire;
		logic [1:0] nreply;
		logic [7:0] reply2;
		logic [7:0] reply1;
		logic [7:0] reply0;
		flags_t     flags;
	} frame_res_t;

	function automatic cmd_t cmd_info(input logic [3:0] code);
		cmd_t c;
		case (code)
			CMD_CA:  c = '{8'hCA, 3'd2, KIND_LINK,  2'd2, 8'h00, 8'hCA, 8'hCA};
			CMD_F5:  c = '{8'hF5, 3'd2, KIND_RESET, 2'd3, 8'hF5, 8'hF5, 8'hF5};
			CMD_B5:  c = '{8'hB5, 3'd4, KIND_CTRL,  2'd2, 8'h00, 8'hB5, 8'hB5};
			CMD_EA:  c = '{8'hEA, 3'd2, KIND_SUM,   2'd2, 8'h00, 8'hEA, 8'hEA};
			CMD_60:  c = '{8'h60, 3'd2, KIND_SUM,   2'd3, 8'h00, 8'h00, 8'h60};
			CMD_E5:  c = '{8'hE5, 3'd7, KIND_SUM,   2'd2, 8'h00, 8'hE5, 8'hE5};
			CMD_E7:  c = '{8'hE7, 3'd7, KIND_SUM,   2'd2, 8'h00, 8'hE7, 8'hE7};
			CMD_E8:  c = '{8'hE8, 3'd3, KIND_SUM,   2'd2, 8'h00, 8'hE8, 8'hE8};
			CMD_E9:  c = '{8'hE9, 3'd3, KIND_SUM,   2'd2, 8'h00, 8'hE9, 8'hE9};
			CMD_D1:  c = '{8'hD1, 3'd5, KIND_DATE,  2'd2, 8'h00, 8'hD1, 8'hD1};
			CMD_D3:  c = '{8'hD3, 3'd4, KIND_TIME,  2'd2, 8'h00, 8'hD3, 8'hD3};
			default: c = '{8'h00, 3'd2, KIND_SUM,   2'd0, 8'h00, 8'h00, 8'h00};
		endcase
		return c;
	endfunction

	// marker byte to command code; idle for unknown or over-long commands
	function automatic logic [3:0] cmd_decode(input logic [7:0] b, input int max_len);
		logic [3:0] code;
		cmd_t       c;
		code = CMD_IDLE;
		for (int i = NUM_CMDS; i >= 1; i--) begin
			c = cmd_info(4'(i));
			if (c.marker == b && int'(c.len) <= max_len) begin
				code = 4'(i);
			end
		end
		return code;
	endfunction

endpackage

`default_nettype wire

// ===== src/mfcr_frame.sv =====
// ----------------------------------------------------------------------------
// mfcr_frame
// Frame engine: marker decode, payload tracking, running checksum and
// decimal value fold; flags a good frame on its last payload byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mfcr_frame
	import mfcr_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	output frame_res_t      res
);

	localparam int CNT_W = $clog2(MAX_PAYLOAD);

	logic [3:0]       cmd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       first_q;
	logic [7:0]       sum_q;
	logic [27:0]      acc_q;

	cmd_t        desc;
	logic        active;
	logic        is_last;
	logic        good;
	logic        acc_en;
	logic [34:0] acc_mul;
	logic [27:0] acc_next;
	flags_t      flags;

	assign desc    = cmd_info(cmd_q);
	assign active  = (cmd_q != CMD_IDLE) && (cmd_q <= 4'(NUM_CMDS));
	assign is_last = ((CNT_W+1)'(cnt_q) + (CNT_W+1)'(1)) == (CNT_W+1)'(desc.len);

	// acc = acc * 100 + byte
	assign acc_mul  = {7'd0, acc_q} * 35'd100;
	assign acc_next = (cnt_q == '0) ? {20'd0, rx_byte} : acc_mul[27:0] + {20'd0, rx_byte};
	assign acc_en   = (desc.kind == KIND_DATE && cnt_q < CNT_W'(DATE_DIGITS)) ||
	                  (desc.kind == KIND_TIME && cnt_q < CNT_W'(TIME_DIGITS));

	always_comb begin
		good  = 1'b0;
		flags = '0;
		case (desc.kind)
			KIND_LINK: begin
				if (first_q == LINK_PLAIN && rx_byte == LINK_PLAIN) begin
					good = 1'b1;
				end else if (first_q == LINK_SEND && rx_byte == LINK_SEND) begin
					good               = 1'b1;
					flags.send_request = 1'b1;
				end
			end
			KIND_RESET: begin
				if (first_q == RESET_PAT && rx_byte == RESET_PAT) begin
					good                = 1'b1;
					flags.reset_request = 1'b1;
				end
			end
			KIND_CTRL: begin
				if (sum_q == rx_byte) begin
					good                 = 1'b1;
					flags.control_update = 1'b1;
					flags.control_value  = first_q;
				end
			end
			KIND_DATE: begin
				if (sum_q == rx_byte) begin
					good              = 1'b1;
					flags.date_update = 1'b1;
					flags.date_value  = acc_q;
				end
			end
			KIND_TIME: begin
				if (sum_q == rx_byte) begin
					good              = 1'b1;
					flags.time_update = 1'b1;
					flags.time_value  = acc_q[21:0];
				end
			end
			default: begin
				good = (sum_q == rx_byte);
			end
		endcase
	end

	always_comb begin
		res.fire   = step && active && is_last && good;
		res.nreply = desc.nreply;
		res.reply0 = desc.reply0;
		res.reply1 = desc.reply1;
		res.reply2 = desc.reply2;
		res.flags  = flags;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= CMD_IDLE;
			cnt_q <= '0;
		end else if (step) begin
			if (!active) begin
				cmd_q <= cmd_decode(rx_byte, MAX_PAYLOAD);
				cnt_q <= '0;
			end else if (is_last) begin
				cmd_q <= CMD_IDLE;
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// payload side: first byte, sum of bytes so far, decimal fold
	always_ff @(posedge clk) begin
		if (step && active) begin
			if (cnt_q == '0) begin
				first_q <= rx_byte;
				sum_q   <= rx_byte;
			end else begin
				sum_q <= sum_q + rx_byte;
			end
			if (acc_en) begin
				acc_q <= acc_next;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/marker_frame_command_receiver_core.sv =====
// ----------------------------------------------------------------------------
// marker_frame_command_receiver_core
// Marker-framed command receiver with reply byte stream and side-band updates.
// ----------------------------------------------------------------------------
// Received bytes enter on the s_ stream (tdata = byte, tuser[0] = line error;
// errored bytes are dropped). A marker byte picks a command, its payload is
// checked against a fixed pattern or a trailing 8-bit additive checksum, and a
// good frame sends two or three reply items on the m_ stream, the last one
// tagged with tlast and carrying any date, time, control, send or reset update
// in tuser. A bad frame or unknown marker sends nothing. Each byte passes one
// input register and then the combinational frame engine, so bytes that cause
// no reply are taken one per cycle while the reply buffer can be loaded; the
// first reply item of a frame is registered in the reply buffer as its last
// byte leaves the input register. The three-entry reply buffer drains one
// item per cycle while the sink is ready, and the byte after a frame waits in
// the input register until the buffer can be loaded (empty, or its last item
// being taken). There is no clearing pass after reset.
`default_nettype none

module marker_frame_command_receiver_core
	import mfcr_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic [7:0]  s_tuser,   // [0] rx_error, [7:1] zero
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [7:0]  m_tdata,   // [7:0] tx_byte
	output      logic        m_tlast,   // last_byte
	output      logic [63:0] m_tuser    // [0] date_update, [28:1] date_value,
	                                    // [29] time_update, [51:30] time_value,
	                                    // [52] control_update, [60:53] control_value,
	                                    // [61] send_request, [62] reset_request, [63] zero
);

	`include "marker_frame_command_receiver_core_macros.svh"

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       err_s1;

	// reply buffer: head item in rep_q[0], rem_q items left
	logic [7:0] rep_q [3];
	logic [1:0] rem_q;
	flags_t     flags_q;

	logic       pop;
	logic       buf_free;
	logic       adv;
	logic       step;
	frame_res_t res;

	assign pop      = m_tvalid && m_tready;
	// buffer can take a new frame this edge
	assign buf_free = (rem_q == 2'd0) || (rem_q == 2'd1 && pop);
	assign adv      = valid_s1 && buf_free;
	assign step     = adv && !err_s1;
	assign s_tready = !valid_s1 || buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			err_s1  <= s_tuser[0];
		end
	end

	mfcr_frame #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.rx_byte(byte_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (res.fire) begin
			rem_q <= res.nreply;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (res.fire) begin
			rep_q[0] <= res.reply0;
			rep_q[1] <= res.reply1;
			rep_q[2] <= res.reply2;
			flags_q  <= res.flags;
		end else if (pop) begin
			rep_q[0] <= rep_q[1];
			rep_q[1] <= rep_q[2];
		end
	end

	assign m_tvalid = (rem_q != 2'd0);
	assign m_tdata  = rep_q[0];
	assign m_tlast  = (rem_q == 2'd1);
	// side-band fields only ride on the last reply item
	assign m_tuser  = m_tlast ? {1'b0, flags_q} : 64'd0;

	`MFCR_ASSERT(a_load_when_free, res.fire |-> (rem_q == 2'd0 || (rem_q == 2'd1 && pop)), "reply buffer loaded while items still pending")
	`MFCR_ASSERT(a_flags_on_last, (m_tvalid && !m_tlast) |-> (m_tuser == 64'd0), "side-band fields set on a non-final reply item")
	`MFCR_ASSERT(a_one_update, m_tvalid |-> ($countones({m_tuser[0], m_tuser[29], m_tuser[52], m_tuser[61], m_tuser[62]}) <= 1), "more than one update flag on a reply item")
	`MFCR_ASSERT_ALWAYS(a_quiet_in_reset, !arst_n |-> !m_tvalid, "reply item shown during reset")

endmodule

`default_nettype wire
